// ===== design/bfra_pkg.sv =====
// ----------------------------------------------------------------------------
// bfra_pkg
// shared widths, codes, types and helpers of the best-fit ring allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bfra_pkg;

   localparam int MAX_BLOCKS = 32;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
   localparam int MODE_W     = 2;
   localparam int ADDR_W     = 31;
   localparam int LEN_W      = 31;

   // request modes
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DUMP  = 2'd2;

   // table write port
   typedef struct packed {
      logic              wr_beg;
      logic              wr_len;
      logic [IDX_W-1:0]  addr;
      logic [ADDR_W-1:0] beg;
      logic [LEN_W-1:0]  len;
   } tbl_wr_type;

   // table read port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } tbl_rd_type;

   // next slot around the ring
   function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] pos);
      if (pos == IDX_W'(MAX_BLOCKS - 1)) begin
         return '0;
      end
      return pos + IDX_W'(1);
   endfunction

endpackage

`default_nettype wire

// ===== design/bfra_if.sv =====
// ----------------------------------------------------------------------------
// bfra_req_if / bfra_rsp_if
// valid/ready channels carrying allocator requests and responses
// ----------------------------------------------------------------------------
`default_nettype none

interface bfra_req_if;
   import bfra_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [ADDR_W-1:0] block_begin;
   logic [LEN_W-1:0]  amount;

   modport source (output valid, output mode, output block_begin, output amount,
                   input ready);
   modport sink   (input valid, input mode, input block_begin, input amount,
                   output ready);
endinterface

interface bfra_rsp_if;
   import bfra_pkg::*;

   logic              valid;
   logic              ready;
   logic              found;
   logic [ADDR_W-1:0] out_begin;
   logic [LEN_W-1:0]  out_length;
   logic              last;

   modport source (output valid, output found, output out_begin, output out_length,
                   output last, input ready);
   modport sink   (input valid, input found, input out_begin, input out_length,
                   input last, output ready);
endinterface

`default_nettype wire

// ===== design/bfra_table.sv =====
// ----------------------------------------------------------------------------
// bfra_table
// block start and length storage, one write and one registered read a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bfra_table (
   input  wire logic                      clock,
   input  wire bfra_pkg::tbl_wr_type      wr,
   input  wire bfra_pkg::tbl_rd_type      rd,
   output logic [bfra_pkg::ADDR_W-1:0]    rd_beg,
   output logic [bfra_pkg::LEN_W-1:0]     rd_len
);
   import bfra_pkg::*;

   logic [ADDR_W-1:0] beg_mem [MAX_BLOCKS];
   logic [LEN_W-1:0]  len_mem [MAX_BLOCKS];
   logic [ADDR_W-1:0] rd_beg_ff;
   logic [LEN_W-1:0]  rd_len_ff;

   always_ff @(posedge clock) begin
      if (wr.wr_beg) begin
         beg_mem[wr.addr] <= wr.beg;
      end
      if (wr.wr_len) begin
         len_mem[wr.addr] <= wr.len;
      end
      if (rd.en) begin
         rd_beg_ff <= beg_mem[rd.addr];
         rd_len_ff <= len_mem[rd.addr];
      end
   end

   assign rd_beg = rd_beg_ff;
   assign rd_len = rd_len_ff;

endmodule

`default_nettype wire

// ===== design/bfra_best.sv =====
// ----------------------------------------------------------------------------
// bfra_best
// compare unit tracking the smallest fitting block of a scan
// ----------------------------------------------------------------------------
`default_nettype none

module bfra_best (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         clear,
   input  wire logic                         cand_vld,
   input  wire logic [bfra_pkg::LEN_W-1:0]   cand_len,
   input  wire logic [bfra_pkg::IDX_W-1:0]   cand_idx,
   input  wire logic [bfra_pkg::LEN_W-1:0]   amount,
   output logic                              have,
   output logic [bfra_pkg::IDX_W-1:0]        pick,
   output logic [bfra_pkg::LEN_W-1:0]        best
);
   import bfra_pkg::*;

   logic             have_ff;
   logic             have_in;
   logic [IDX_W-1:0] pick_ff;
   logic [LEN_W-1:0] best_ff;
   logic             take;

   // strictly smaller wins, so ties keep the first block met
   assign take    = cand_vld && (cand_len >= amount) && (!have_ff || (cand_len < best_ff));
   assign have_in = clear ? 1'b0 : (have_ff || take);

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
      if (take && !clear) begin
         pick_ff <= cand_idx;
         best_ff <= cand_len;
      end
   end

   assign have = have_ff;
   assign pick = pick_ff;
   assign best = best_ff;

endmodule

`default_nettype wire

// ===== design/best_fit_ring_allocator_top.sv =====
// ----------------------------------------------------------------------------
// best_fit_ring_allocator_top
// best-fit allocator over a ring of free blocks kept in load order
// ----------------------------------------------------------------------------
// usage:
//   req_ch carries load (mode 0), query (mode 1) and dump (mode 2) transfers;
//   rsp_ch returns found, out_begin, out_length and last. a transfer is taken
//   only while the sequencer is idle, and the next one waits for it to finish.
//   load: no response; dropped once all slots have been used.
//   query: the compare unit walks all MAX_BLOCKS slots from the head, one
//   per cycle behind the table read, then one response with last set; a
//   block cut to zero adds a walk over the live flags to find the new head.
//   dump: returns each live slot from the head as a response, waiting on
//   response stalls; an empty ring gives one not-found response.
//   mode 3 is ignored. the response register frees the request side as soon
//   as the sequencer is done; a stalled receiver holds the sequencer only
//   when it has a further response to write.
//   reset (synchronous) clears the live flags, head and counters; the block
//   table itself is not cleared since data read from dead slots is never used.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_ring_allocator_top (
   input  wire logic  clock,
   input  wire logic  reset,
   bfra_req_if.sink   req_ch,
   bfra_rsp_if.source rsp_ch
);
   import bfra_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_QSCAN = 8'b0000_0010,
      S_QPICK = 8'b0000_0100,
      S_QCUT  = 8'b0000_1000,
      S_SEEK  = 8'b0001_0000,
      S_MISS  = 8'b0010_0000,
      S_DSCAN = 8'b0100_0000,
      S_DEMIT = 8'b1000_0000
   } state_type;

   // sequencer and ring state
   state_type              state_ff, state_in;
   logic [MAX_BLOCKS-1:0]  live_ff, live_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic [CNT_W-1:0]       step_ff, step_in;
   logic [CNT_W-1:0]       seen_ff, seen_in;
   logic [LEN_W-1:0]       amount_ff, amount_in;

   // scan stage behind the table read
   logic                   stage_vld_ff, stage_vld_in;
   logic [IDX_W-1:0]       stage_idx_ff, stage_idx_in;

   // response register
   logic                   rsp_vld_ff, rsp_vld_in;
   logic                   found_ff, found_in;
   logic [ADDR_W-1:0]      obeg_ff, obeg_in;
   logic [LEN_W-1:0]       olen_ff, olen_in;
   logic                   last_ff, last_in;

   tbl_wr_type             tbl_wr;
   tbl_rd_type             tbl_rd;
   logic [ADDR_W-1:0]      rd_beg;
   logic [LEN_W-1:0]       rd_len;

   logic                   best_clear;
   logic                   have;
   logic [IDX_W-1:0]       pick;
   logic [LEN_W-1:0]       best;

   logic                   req_xfer;
   logic                   out_free;
   logic                   emit;
   logic [LEN_W-1:0]       remain;
   logic                   dump_last;

   assign req_xfer  = req_ch.valid && req_ch.ready;
   assign out_free  = !rsp_vld_ff || rsp_ch.ready;
   assign remain    = best - amount_ff;
   assign dump_last = (seen_ff + CNT_W'(1)) == count_ff;

   bfra_table u_table (
      .clock  (clock),
      .wr     (tbl_wr),
      .rd     (tbl_rd),
      .rd_beg (rd_beg),
      .rd_len (rd_len)
   );

   bfra_best u_best (
      .clock    (clock),
      .reset    (reset),
      .clear    (best_clear),
      .cand_vld (stage_vld_ff),
      .cand_len (rd_len),
      .cand_idx (stage_idx_ff),
      .amount   (amount_ff),
      .have     (have),
      .pick     (pick),
      .best     (best)
   );

   always_comb begin
      state_in     = state_ff;
      live_in      = live_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      seen_in      = seen_ff;
      amount_in    = amount_ff;
      stage_vld_in = 1'b0;
      stage_idx_in = stage_idx_ff;
      emit         = 1'b0;
      found_in     = found_ff;
      obeg_in      = obeg_ff;
      olen_in      = olen_ff;
      last_in      = last_ff;
      best_clear   = 1'b0;
      tbl_wr       = '0;
      tbl_rd       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_ch.mode)
                  MODE_LOAD: begin
                     // append unless every slot has been handed out
                     if (fill_ff != CNT_W'(MAX_BLOCKS)) begin
                        tbl_wr.wr_beg = 1'b1;
                        tbl_wr.wr_len = 1'b1;
                        tbl_wr.addr   = fill_ff[IDX_W-1:0];
                        tbl_wr.beg    = req_ch.block_begin;
                        tbl_wr.len    = req_ch.amount;
                        live_in[fill_ff[IDX_W-1:0]] = 1'b1;
                        if (count_ff == '0) begin
                           head_in = fill_ff[IDX_W-1:0];
                        end
                        fill_in  = fill_ff + CNT_W'(1);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_QUERY: begin
                     amount_in  = req_ch.amount;
                     best_clear = 1'b1;
                     pos_in     = head_ff;
                     step_in    = '0;
                     state_in   = S_QSCAN;
                  end
                  MODE_DUMP: begin
                     if (count_ff == '0) begin
                        state_in = S_MISS;
                     end else begin
                        pos_in   = head_ff;
                        step_in  = '0;
                        seen_in  = '0;
                        state_in = S_DSCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_QSCAN: begin
            // read one slot a cycle, compare it the cycle after
            if (step_ff != CNT_W'(MAX_BLOCKS)) begin
               tbl_rd.en    = 1'b1;
               tbl_rd.addr  = pos_ff;
               stage_vld_in = live_ff[pos_ff];
               stage_idx_in = pos_ff;
               pos_in       = next_pos(pos_ff);
               step_in      = step_ff + CNT_W'(1);
            end else begin
               state_in = S_QPICK;
            end
         end

         S_QPICK: begin
            if (have) begin
               tbl_rd.en   = 1'b1;
               tbl_rd.addr = pick;
               state_in    = S_QCUT;
            end else begin
               state_in = S_MISS;
            end
         end

         S_QCUT: begin
            if (out_free) begin
               emit          = 1'b1;
               found_in      = 1'b1;
               obeg_in       = rd_beg;
               olen_in       = remain;
               last_in       = 1'b1;
               tbl_wr.wr_len = 1'b1;
               tbl_wr.addr   = pick;
               tbl_wr.len    = remain;
               if (remain == '0) begin
                  // block used up: drop it and look for the next live slot
                  live_in[pick] = 1'b0;
                  count_in      = count_ff - CNT_W'(1);
                  pos_in        = next_pos(pick);
                  step_in       = CNT_W'(1);
                  state_in      = S_SEEK;
               end else begin
                  head_in  = pick;
                  state_in = S_IDLE;
               end
            end
         end

         S_SEEK: begin
            if (step_ff == CNT_W'(MAX_BLOCKS)) begin
               state_in = S_IDLE;
            end else if (live_ff[pos_ff]) begin
               head_in  = pos_ff;
               state_in = S_IDLE;
            end else begin
               pos_in  = next_pos(pos_ff);
               step_in = step_ff + CNT_W'(1);
            end
         end

         S_MISS: begin
            if (out_free) begin
               emit     = 1'b1;
               found_in = 1'b0;
               obeg_in  = '0;
               olen_in  = '0;
               last_in  = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_DSCAN: begin
            if (step_ff == CNT_W'(MAX_BLOCKS)) begin
               state_in = S_IDLE;
            end else if (live_ff[pos_ff]) begin
               tbl_rd.en   = 1'b1;
               tbl_rd.addr = pos_ff;
               state_in    = S_DEMIT;
            end else begin
               pos_in  = next_pos(pos_ff);
               step_in = step_ff + CNT_W'(1);
            end
         end

         S_DEMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               found_in = 1'b1;
               obeg_in  = rd_beg;
               olen_in  = rd_len;
               last_in  = dump_last;
               seen_in  = seen_ff + CNT_W'(1);
               pos_in   = next_pos(pos_ff);
               step_in  = step_ff + CNT_W'(1);
               state_in = dump_last ? S_IDLE : S_DSCAN;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response register: load on a new response, drop on a transfer
   always_comb begin
      if (emit) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         step_ff      <= '0;
         seen_ff      <= '0;
         stage_vld_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         step_ff      <= step_in;
         seen_ff      <= seen_in;
         stage_vld_ff <= stage_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
      amount_ff    <= amount_in;
      stage_idx_ff <= stage_idx_in;
      found_ff     <= found_in;
      obeg_ff      <= obeg_in;
      olen_ff      <= olen_in;
      last_ff      <= last_in;
   end

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.found      = found_ff;
   assign rsp_ch.out_begin  = obeg_ff;
   assign rsp_ch.out_length = olen_ff;
   assign rsp_ch.last       = last_ff;

endmodule

`default_nettype wire

// ===== tb/sv/bfra_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfra_checker
// shadow free list of the allocator; compares every response in order
// ----------------------------------------------------------------------------
module bfra_checker (
   input  logic clock,
   input  logic reset,
   bfra_req_if  req_mon,
   bfra_rsp_if  rsp_mon,
   output int   error_count,
   output int   replies_due
);
   import bfra_pkg::*;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  remain;
      logic              last;
   } reply_type;

   logic [ADDR_W-1:0] shadow_begin [MAX_BLOCKS];
   logic [LEN_W-1:0]  shadow_len   [MAX_BLOCKS];
   logic              shadow_live  [MAX_BLOCKS];
   logic [IDX_W-1:0]  shadow_head;
   logic [CNT_W-1:0]  shadow_fill;
   logic [CNT_W-1:0]  shadow_count;
   reply_type         due_replies [$];
   reply_type         want;
   int                mismatches = 0;

   function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] from,
                                                  input int step);
      return IDX_W'((int'(from) + step) % MAX_BLOCKS);
   endfunction

   // applies one accepted request to the shadow list and queues its replies
   task automatic serve_request(input logic [MODE_W-1:0] mode,
                                input logic [ADDR_W-1:0] start,
                                input logic [LEN_W-1:0]  amount);
      logic             hit;
      logic             moved;
      logic [IDX_W-1:0] pick;
      logic [IDX_W-1:0] pos;
      logic [LEN_W-1:0] best;
      int               listed;
      hit    = 1'b0;
      moved  = 1'b0;
      pick   = '0;
      best   = '0;
      listed = 0;
      case (mode)
         MODE_LOAD: begin
            if (shadow_fill < CNT_W'(MAX_BLOCKS)) begin
               shadow_begin[shadow_fill[IDX_W-1:0]] = start;
               shadow_len[shadow_fill[IDX_W-1:0]]   = amount;
               shadow_live[shadow_fill[IDX_W-1:0]]  = 1'b1;
               if (shadow_count == '0) begin
                  shadow_head = shadow_fill[IDX_W-1:0];
               end
               shadow_fill++;
               shadow_count++;
            end
         end
         MODE_QUERY: begin
            for (int i = 0; i < MAX_BLOCKS; i++) begin
               pos = ring_slot(shadow_head, i);
               if (shadow_live[pos] && shadow_len[pos] >= amount &&
                   (!hit || shadow_len[pos] < best)) begin
                  hit  = 1'b1;
                  pick = pos;
                  best = shadow_len[pos];
               end
            end
            if (!hit) begin
               due_replies.push_back(reply_type'{1'b0, '0, '0, 1'b1});
            end else begin
               shadow_len[pick] = best - amount;
               due_replies.push_back(reply_type'{1'b1, shadow_begin[pick],
                                                 shadow_len[pick], 1'b1});
               if (shadow_len[pick] == '0) begin
                  // emptied block leaves the ring, head goes to the next live one
                  shadow_live[pick] = 1'b0;
                  shadow_count--;
                  for (int i = 1; i < MAX_BLOCKS; i++) begin
                     pos = ring_slot(pick, i);
                     if (!moved && shadow_live[pos]) begin
                        shadow_head = pos;
                        moved       = 1'b1;
                     end
                  end
               end else begin
                  shadow_head = pick;
               end
            end
         end
         MODE_DUMP: begin
            if (shadow_count == '0) begin
               due_replies.push_back(reply_type'{1'b0, '0, '0, 1'b1});
            end else begin
               for (int i = 0; i < MAX_BLOCKS; i++) begin
                  pos = ring_slot(shadow_head, i);
                  if (shadow_live[pos]) begin
                     listed++;
                     due_replies.push_back(reply_type'{1'b1, shadow_begin[pos], shadow_len[pos],
                                                       listed == int'(shadow_count)});
                  end
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            shadow_live[i] = 1'b0;
         end
         shadow_head  = '0;
         shadow_fill  = '0;
         shadow_count = '0;
         due_replies.delete();
      end else begin
         // responses first, so a reply never meets the request of the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_replies.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual found=%0d",
                        $time, rsp_mon.found);
               $display("%0t:    begin=0x%0h length=0x%0h last=%0d",
                        $time, rsp_mon.out_begin, rsp_mon.out_length, rsp_mon.last);
               mismatches++;
            end else begin
               want = due_replies.pop_front();
               if (rsp_mon.found !== want.found) begin
                  $display("%0t: found expected %0d actual %0d", $time, want.found, rsp_mon.found);
                  mismatches++;
               end
               if (rsp_mon.out_begin !== want.start) begin
                  $display("%0t: out_begin expected 0x%0h actual 0x%0h",
                           $time, want.start, rsp_mon.out_begin);
                  mismatches++;
               end
               if (rsp_mon.out_length !== want.remain) begin
                  $display("%0t: out_length expected 0x%0h actual 0x%0h",
                           $time, want.remain, rsp_mon.out_length);
                  mismatches++;
               end
               if (rsp_mon.last !== want.last) begin
                  $display("%0t: last expected %0d actual %0d", $time, want.last, rsp_mon.last);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            serve_request(req_mon.mode, req_mon.block_begin, req_mon.amount);
         end
      end
      error_count <= mismatches;
      replies_due <= due_replies.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// request stimulus, response back-pressure and verdict for the allocator
// ----------------------------------------------------------------------------
module tb_top;
   import bfra_pkg::*;

   // how the two sides idle during a stretch of the random traffic
   typedef enum int {
      PH_STEADY,
      PH_SRC_GAPS,
      PH_HOLD,
      PH_SNK_STALLS,
      PH_BOTH
   } idle_phase_type;

   localparam int RANDOM_ITEMS  = 145;
   localparam int SEGMENTS      = 5;
   localparam int SEGMENT_ITEMS = RANDOM_ITEMS / SEGMENTS;
   localparam int HOLD_CYCLES   = 400;
   // worst dump walk plus a query walk and its head search
   localparam int TAIL_CYCLES   = 4 * MAX_BLOCKS + 16;
   localparam int CYCLE_LIMIT   = 600000;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [ADDR_W-1:0] ADDR_ALL    = {ADDR_W{1'b1}};
   localparam logic [LEN_W-1:0]  LEN_ALL     = {LEN_W{1'b1}};

   logic           clock = 1'b0;
   logic           reset;
   idle_phase_type phase       = PH_STEADY;
   int             cycle_count = 0;
   int             hold_count  = 0;
   int             loads_sent  = 0;
   int             counted     = 0;
   int             error_count;
   int             replies_due;

   bfra_req_if req_ch ();
   bfra_rsp_if rsp_ch ();

   best_fit_ring_allocator_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bfra_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .error_count (error_count),
      .replies_due (replies_due)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog, generous against the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // response side: one long hold-off, then random stalls by phase
   always @(posedge clock) begin
      if (phase == PH_HOLD && hold_count < HOLD_CYCLES) begin
         // receiver holds off while the sender keeps offering transfers
         hold_count   <= hold_count + 1;
         rsp_ch.ready <= 1'b0;
      end else if (phase == PH_SNK_STALLS) begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= 48);
      end else if (phase == PH_BOTH) begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= 15);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // offer one request and wait for its transfer
   task automatic send_item(input logic [MODE_W-1:0] mode,
                            input logic [ADDR_W-1:0] start,
                            input logic [LEN_W-1:0]  amount);
      // random gaps before the transfer; valid only drops when a gap is taken
      while ((phase == PH_SRC_GAPS && $urandom_range(0, 99) < 48) ||
             (phase == PH_BOTH && $urandom_range(0, 99) < 15)) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= mode;
      req_ch.block_begin <= start;
      req_ch.amount      <= amount;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      // ignored modes and loads into a full table do not count as traffic
      if (mode == MODE_LOAD) begin
         if (loads_sent < MAX_BLOCKS) begin
            counted++;
         end
         loads_sent++;
      end else if (mode != MODE_UNUSED) begin
         counted++;
      end
   endtask

   // sender pauses until every outstanding response has come back
   task automatic drain_replies();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (replies_due != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int               target;
      int               pick;
      int               load_share;
      int               size_pick;
      logic [LEN_W-1:0] size;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.mode        <= MODE_LOAD;
      req_ch.block_begin <= '0;
      req_ch.amount      <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty ring, extremes, ties, removals and wrap of the head
      send_item(MODE_QUERY, '0, LEN_W'(5));             // miss on an empty ring
      send_item(MODE_DUMP, '0, '0);                     // dump of an empty ring
      send_item(MODE_UNUSED, ADDR_ALL, LEN_ALL);        // unused mode, no response
      send_item(MODE_LOAD, ADDR_ALL, LEN_ALL);          // longest block, head follows
      send_item(MODE_LOAD, '0, '0);                     // zero-length block
      send_item(MODE_QUERY, '0, LEN_ALL);               // takes the longest block whole
      send_item(MODE_DUMP, '0, '0);
      send_item(MODE_QUERY, '0, '0);                    // zero request empties the ring
      send_item(MODE_DUMP, ADDR_ALL, LEN_ALL);
      send_item(MODE_LOAD, ADDR_W'('h1000), LEN_W'(10)); // load into an empty ring
      send_item(MODE_LOAD, ADDR_W'('h2000), LEN_W'(10)); // tie with the one before
      send_item(MODE_LOAD, ADDR_W'('h3000), LEN_W'(4));
      send_item(MODE_QUERY, '0, LEN_W'(20));            // miss with a populated ring
      send_item(MODE_QUERY, '0, LEN_W'(7));             // tie, first from the head wins
      send_item(MODE_QUERY, '0, LEN_W'(3));             // exact fit, block removed
      send_item(MODE_QUERY, '0, LEN_W'(4));             // removal wraps the head
      send_item(MODE_LOAD, ADDR_W'('h4000), LEN_W'(10));
      send_item(MODE_QUERY, '0, LEN_W'(2));
      send_item(MODE_QUERY, '0, LEN_W'(9));
      send_item(MODE_QUERY, '0, LEN_W'(8));
      send_item(MODE_DUMP, '0, '0);
      send_item(MODE_QUERY, '0, '0);                    // zero request on a live block
      send_item(MODE_DUMP, '0, '0);
      drain_replies();

      // random traffic, one idling pattern per segment, drained in between
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         phase  <= idle_phase_type'(seg);
         target  = counted + SEGMENT_ITEMS;
         while (counted < target) begin
            pick       = $urandom_range(0, 99);
            load_share = (loads_sent < MAX_BLOCKS) ? 18 : 4;
            if (pick < 3) begin
               send_item(MODE_UNUSED, ADDR_W'($urandom), LEN_W'($urandom));
            end else if (pick < 3 + load_share) begin
               // mostly short blocks so queries cut and empty them
               size_pick = $urandom_range(0, 9);
               if (size_pick == 0) begin
                  size = '0;
               end else if (size_pick == 1) begin
                  size = LEN_W'($urandom);
               end else begin
                  size = LEN_W'($urandom_range(1, 48));
               end
               send_item(MODE_LOAD, ADDR_W'($urandom), size);
            end else if (pick < 15 + load_share) begin
               send_item(MODE_DUMP, ADDR_W'($urandom), LEN_W'($urandom));
            end else begin
               size_pick = $urandom_range(0, 19);
               if (size_pick < 2) begin
                  size = '0;
               end else if (size_pick < 5) begin
                  size = LEN_W'($urandom);
               end else begin
                  size = LEN_W'($urandom_range(0, 24));
               end
               send_item(MODE_QUERY, ADDR_W'($urandom), size);
            end
         end
         drain_replies();
      end

      phase <= PH_STEADY;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && replies_due == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
